// ----- rtl/core/keyed_bit_partition_permute_top_macros.svh -----
// Assertion macros used by the RTL that checks itself.
`ifndef KEYED_BIT_PARTITION_PERMUTE_TOP_MACROS_SVH
`define KEYED_BIT_PARTITION_PERMUTE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk outside reset.
`define KBPP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk outside reset.
`define KBPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/kbpp_pkg.sv -----
package kbpp_pkg;

	localparam int unsigned ByteW = 8;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_RDKEY = 4'b0010,
		ST_CHK   = 4'b0100,
		ST_BYTE  = 4'b1000
	} kbpp_state_t;

	// Strobes from the sequencer to the block store.
	typedef struct packed {
		logic wr_en;
		logic key_rd_en;
		logic byte_rd_en;
	} kbpp_mem_ctl_t;

endpackage

// ----- rtl/core/kbpp_store.sv -----
module kbpp_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                    clk,
	input  kbpp_pkg::kbpp_mem_ctl_t ctl,
	input  logic [AW-1:0]           wr_addr,
	input  logic [7:0]              wr_byte,
	input  logic                    wr_key,
	input  logic [AW-1:0]           key_addr,
	input  logic [AW-1:0]           byte_addr,
	output logic                    key_rd,
	output logic [7:0]              byte_rd
);
	import kbpp_pkg::*;

	logic [ByteW-1:0] byte_mem [DEPTH];
	logic             key_mem  [DEPTH];
	logic [ByteW-1:0] byte_rd_q;
	logic             key_rd_q;

	// Both stores share the write address; reads hold their last value when not enabled.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			byte_mem[wr_addr] <= wr_byte;
			key_mem[wr_addr]  <= wr_key;
		end
		if (ctl.key_rd_en) begin
			key_rd_q <= key_mem[key_addr];
		end
		if (ctl.byte_rd_en) begin
			byte_rd_q <= byte_mem[byte_addr];
		end
	end

	assign key_rd  = key_rd_q;
	assign byte_rd = byte_rd_q;

endmodule

// ----- rtl/core/keyed_bit_partition_permute_top.sv -----
// Channel  Direction  Payload
// s_*      in         tdata[7:0] data_byte, tuser key_bit, tlast last
// m_*      out        tdata[7:0] out_byte, tuser[0] out_key_bit, tuser[1] truncated, tlast
// cfg_*    in         cfg_data mode (0 forward partition, 1 inverse restore)
//
// Items are stored as they are loaded; the block is emitted after the last item.
// Forward mode scans the key store twice, once for each key value, and skips the
// entries that do not match the pass. The single key read port and the registered
// reads of the stores set the pace of both modes.
// Reset clears the counters and the sequencer; the stores are not cleared.
// A stalled output holds in the output register; the sequencer waits behind it.
`include "keyed_bit_partition_permute_top_macros.svh"

module keyed_bit_partition_permute_top #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] key_bit
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] out_key_bit, [1] truncated
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import kbpp_pkg::*;

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_LEN);
	localparam logic [CW-1:0] One = CW'(1);

	kbpp_state_t   state_q;
	kbpp_mem_ctl_t ctl;

	logic          mode_q;
	logic [CW-1:0] cnt_q, zcnt_q;
	logic          ovf_q;
	logic [CW-1:0] n_q, z_q, idx_q, emit_q, lo_q, hi_q;
	logic          pass_q, blk_mode_q, blk_ovf_q;
	logic          cur_key_q;
	logic          m_valid_q, m_key_q, m_trunc_q, m_last_q;
	logic [7:0]    m_byte_q;

	logic          load_fire, room, match, at_end, done_adv, out_free, adv, out_load;
	logic          key_rd;
	logic [7:0]    byte_rd;
	logic [CW-1:0] next_idx, src, z_next;
	logic [AW-1:0] key_addr, byte_addr;

	assign s_tready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign load_fire = s_tvalid & s_tready;
	assign room      = (cnt_q != MaxCount);
	assign z_next    = zcnt_q + CW'(room & ~s_tuser);

	// Forward mode only emits entries whose key matches the current pass.
	assign match    = blk_mode_q | (key_rd == pass_q);
	assign at_end   = (idx_q == n_q - One);
	assign done_adv = at_end & (blk_mode_q | pass_q);
	assign next_idx = at_end ? '0 : idx_q + One;
	assign src      = key_rd ? hi_q : lo_q;
	assign out_free = ~m_valid_q | m_tready;
	assign out_load = (state_q == ST_BYTE) & out_free;
	assign adv      = ((state_q == ST_CHK) & ~match) | out_load;

	assign ctl.wr_en      = load_fire & room;
	assign ctl.key_rd_en  = (state_q == ST_RDKEY) | (adv & ~done_adv);
	assign ctl.byte_rd_en = (state_q == ST_CHK) & match;
	assign key_addr  = (state_q == ST_RDKEY) ? idx_q[AW-1:0] : next_idx[AW-1:0];
	assign byte_addr = blk_mode_q ? src[AW-1:0] : idx_q[AW-1:0];

	kbpp_store #(
		.DEPTH(MAX_LEN),
		.AW   (AW)
	) u_store (
		.clk      (clk),
		.ctl      (ctl),
		.wr_addr  (cnt_q[AW-1:0]),
		.wr_byte  (s_tdata),
		.wr_key   (s_tuser),
		.key_addr (key_addr),
		.byte_addr(byte_addr),
		.key_rd   (key_rd),
		.byte_rd  (byte_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			zcnt_q     <= '0;
			ovf_q      <= 1'b0;
			n_q        <= '0;
			z_q        <= '0;
			idx_q      <= '0;
			emit_q     <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			pass_q     <= 1'b0;
			blk_mode_q <= 1'b0;
			blk_ovf_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_fire) begin
						if (s_tlast) begin
							n_q        <= room ? cnt_q + One : cnt_q;
							z_q        <= z_next;
							blk_ovf_q  <= ovf_q | ~room;
							blk_mode_q <= mode_q;
							idx_q      <= '0;
							emit_q     <= '0;
							pass_q     <= 1'b0;
							lo_q       <= '0;
							hi_q       <= z_next;
							cnt_q      <= '0;
							zcnt_q     <= '0;
							ovf_q      <= 1'b0;
							state_q    <= ST_RDKEY;
						end else if (room) begin
							cnt_q  <= cnt_q + One;
							zcnt_q <= z_next;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_RDKEY: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (match) begin
						if (blk_mode_q) begin
							if (key_rd) begin
								hi_q <= hi_q + One;
							end else begin
								lo_q <= lo_q + One;
							end
						end
						state_q <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					if (out_free) begin
						emit_q <= emit_q + One;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			// Step to the next stored position, wrapping into the second forward pass.
			if (adv) begin
				if (done_adv) begin
					state_q <= ST_LOAD;
				end else begin
					idx_q   <= next_idx;
					state_q <= ST_CHK;
					if (at_end) begin
						pass_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_CHK) && match) begin
			cur_key_q <= key_rd;
		end
		if (out_load) begin
			m_byte_q  <= byte_rd;
			m_key_q   <= cur_key_q;
			m_trunc_q <= blk_ovf_q;
			m_last_q  <= (emit_q == n_q - One);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = {m_trunc_q, m_key_q};
	assign m_tlast  = m_last_q;

	`KBPP_ASSERT_NOW(a_fill_bound, 1'b1, cnt_q <= MaxCount, "item count beyond store depth")
	`KBPP_ASSERT_NOW(a_emit_bound, state_q == ST_BYTE, emit_q < n_q, "too many results")
	`KBPP_ASSERT_NOW(a_inv_ptrs, (state_q != ST_LOAD) && blk_mode_q, (lo_q <= z_q) && (hi_q <= n_q), "inverse source pointer out of its partition")
	`KBPP_ASSERT_NEXT(a_out_hold, m_valid_q && !m_tready, m_valid_q, "pending result dropped")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned BLK_MAX = 64;
	localparam int unsigned HOLD_OFF = 500;
	localparam int unsigned SETTLE = 3 * BLK_MAX + 8;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned PHASE_ITEMS = 66;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic MODE_FORWARD = 1'b0;
	localparam logic MODE_INVERSE = 1'b1;

	typedef enum int unsigned {
		KEYS_MIXED,
		KEYS_ZERO,
		KEYS_ONE
	} key_pattern_t;

	typedef struct packed {
		logic [kbpp_pkg::ByteW-1:0] data;
		logic                       key;
		logic                       trunc;
		logic                       last;
	} permuted_item_t;

	// Holds the block being loaded and the queue of permuted items still owed by the block.
	class permute_scoreboard;
		logic [7:0]     held_data[BLK_MAX];
		logic           held_key[BLK_MAX];
		int unsigned    held_count;
		int unsigned    zero_keys;
		logic           dropped;
		logic           mode;
		permuted_item_t awaited[$];
		int unsigned    mismatches;

		function new();
			held_count = 0;
			zero_keys = 0;
			dropped = 1'b0;
			mode = MODE_FORWARD;
			mismatches = 0;
		endfunction

		function void set_mode(logic m);
			mode = m;
		endfunction

		function void emit(logic [7:0] d, logic k, logic l);
			permuted_item_t r;
			r.data = d;
			r.key = k;
			r.trunc = dropped;
			r.last = l;
			awaited = {awaited, r};
		endfunction

		function void note_item(logic [7:0] d, logic k, logic l);
			int unsigned next_lo;
			int unsigned next_hi;
			int unsigned src;
			int unsigned n_out;
			if (held_count < BLK_MAX) begin
				held_data[held_count] = d;
				held_key[held_count] = k;
				held_count++;
				if (!k)
					zero_keys++;
			end else begin
				dropped = 1'b1;
			end
			if (!l)
				return;
			n_out = 0;
			if (mode == MODE_FORWARD) begin
				for (int pass = 0; pass < 2; pass++) begin
					for (int unsigned i = 0; i < held_count; i++) begin
						if (held_key[i] == (pass == 1)) begin
							emit(held_data[i], pass == 1, n_out + 1 == held_count);
							n_out++;
						end
					end
				end
			end else begin
				// The first zero_keys stored bytes feed zero-key positions, the rest feed one-key positions.
				next_lo = 0;
				next_hi = zero_keys;
				for (int unsigned i = 0; i < held_count; i++) begin
					if (held_key[i]) begin
						src = next_hi;
						next_hi++;
					end else begin
						src = next_lo;
						next_lo++;
					end
					emit(held_data[src], held_key[i], i + 1 == held_count);
				end
			end
			held_count = 0;
			zero_keys = 0;
			dropped = 1'b0;
		endfunction

		function void check_output(permuted_item_t got);
			permuted_item_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected item: data %h key %b trunc %b last %b",
						$time, got.data, got.key, got.trunc, got.last);
				return;
			end
			want = awaited.pop_front();
			if (got.data != want.data || got.key != want.key || got.trunc != want.trunc ||
					got.last != want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$write("%0t: mismatch: expected data %h key %b trunc %b last %b, ",
						$time, want.data, want.key, want.trunc, want.last);
					$display("got data %h key %b trunc %b last %b",
						got.data, got.key, got.trunc, got.last);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;    // [7:0] data_byte
	logic       s_tuser = 1'b0;  // [0] key_bit
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;         // [7:0] out_byte
	logic [1:0] m_tuser;         // [0] out_key_bit, [1] truncated
	logic       m_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;

	permute_scoreboard board = new();
	int unsigned src_calm = 0;
	int unsigned snk_calm = 0;
	logic pressure_go = 1'b0;
	logic pressure_done = 1'b0;

	keyed_bit_partition_permute_top #(
		.MAX_LEN(BLK_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Now and then a side runs a stretch of items with no idle cycles at all.
	function automatic int unsigned draw_gap(inout int unsigned calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(10, 50);
		return $urandom_range(0, 18);
	endfunction

	task automatic send_item(input logic [7:0] d, input logic k, input logic l);
		int unsigned gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= k;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		board.note_item(d, k, l);
	endtask

	task automatic send_block(input int unsigned len);
		key_pattern_t pattern;
		int unsigned pick;
		logic kb;
		pick = $urandom_range(0, 5);
		pattern = (pick == 0) ? KEYS_ZERO : (pick == 1) ? KEYS_ONE : KEYS_MIXED;
		for (int unsigned i = 0; i < len; i++) begin
			case (pattern)
				KEYS_ZERO: kb = 1'b0;
				KEYS_ONE:  kb = 1'b1;
				default:   kb = 1'($urandom_range(0, 1));
			endcase
			send_item(8'($urandom_range(0, 255)), kb, i + 1 == len);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_mode(m);
	endtask

	initial begin
		int unsigned phase_items;
		int unsigned len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(MODE_FORWARD);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hA5, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b1);
		send_item(8'hFE, 1'b0, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'hAA, 1'b0, 1'b1);

		write_mode(MODE_INVERSE);
		send_item(8'h11, 1'b0, 1'b0);
		send_item(8'h22, 1'b1, 1'b0);
		send_item(8'h33, 1'b1, 1'b0);
		send_item(8'h44, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hC3, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			write_mode((ph % 2 == 0) ? MODE_FORWARD : MODE_INVERSE);
			// Each phase opens with a full or an overlong block; the rest are mostly short.
			case (ph)
				0: len = BLK_MAX;
				1: len = BLK_MAX + 3;
				2: len = $urandom_range(BLK_MAX + 1, BLK_MAX + 6);
				default: len = BLK_MAX;
			endcase
			if (ph == 0) begin
				// The sender keeps pushing while the receiver holds off, so the block backs up.
				pressure_go = 1'b1;
				src_calm = 80;
			end
			send_block(len);
			phase_items = len;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, BLK_MAX);
				else
					len = $urandom_range(1, 12);
				send_block(len);
				phase_items += len;
			end
		end

		wait_drained();
		if (board.awaited.size() != 0)
			$display("%0d expected items never arrived", board.awaited.size());
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		int unsigned gap;
		permuted_item_t got;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(snk_calm);
			if (pressure_go && !pressure_done) begin
				gap = HOLD_OFF;
				pressure_done = 1'b1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			got.data = m_tdata;
			got.key = m_tuser[0];
			got.trunc = m_tuser[1];
			got.last = m_tlast;
			board.check_output(got);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No item moved for %0d cycles", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/kbpp_pkg.sv
rtl/core/kbpp_store.sv
rtl/core/keyed_bit_partition_permute_top.sv
test/tb_top.sv
